@@ hw/rtl/ubx_frame_receiver_assert.svh @@
// Assertion macros shared by the frame receiver RTL.
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UBXFR_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UBXFR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ hw/rtl/ubxfr_pkg.sv @@
// Shared types and constants of the UBX frame receiver.
package ubxfr_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2
	} kind_t;

	// Control of the checksum unit for one request.
	typedef struct packed {
		logic       add;
		logic       clear;
		logic [7:0] data;
	} fl_ctrl_t;

	// Running Fletcher-8 sums.
	typedef struct packed {
		logic [7:0] sum_a;
		logic [7:0] sum_b;
	} fl_sums_t;

endpackage

@@ hw/rtl/ubxfr_stream_if.sv @@
// Valid/ready stream interfaces for received bytes and frame results.
interface ubxfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ubxfr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] payload_index;
	logic [7:0]  msg_class;
	logic [7:0]  msg_id;
	logic [15:0] payload_length;

	modport source (output valid, output kind, output data_byte, output payload_index,
		output msg_class, output msg_id, output payload_length, input ready);
	modport sink (input valid, input kind, input data_byte, input payload_index,
		input msg_class, input msg_id, input payload_length, output ready);
endinterface

@@ hw/rtl/ubxfr_fletcher.sv @@
// Fletcher-8 running checksum over header and payload bytes.
module ubxfr_fletcher (
	input  logic                clk,
	input  logic                arst_n,
	input  ubxfr_pkg::fl_ctrl_t ctrl,
	output ubxfr_pkg::fl_sums_t sums
);

	logic [7:0] sum_a_q, sum_b_q;
	logic [7:0] base_a, base_b, next_a, next_b;

	// A clear restarts both sums from zero before this byte is added.
	always_comb begin
		base_a = ctrl.clear ? 8'd0 : sum_a_q;
		base_b = ctrl.clear ? 8'd0 : sum_b_q;
		next_a = base_a + ctrl.data;
		next_b = base_b + next_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
		end else if (ctrl.add) begin
			sum_a_q <= next_a;
			sum_b_q <= next_b;
		end
	end

	assign sums.sum_a = sum_a_q;
	assign sums.sum_b = sum_b_q;

endmodule

@@ hw/rtl/ubx_frame_receiver.sv @@
// UBX frame receiver: takes one byte per cycle, unless stalled as below,
// and streams payload bytes and a checksum verdict. Each byte that
// produces a result shows it on the result channel in the cycle after
// acceptance, from a single output register. The byte request is refused
// only while that register holds a result the sink has not taken. Bytes
// are scanned for the sync pair B5 62; class, id and little-endian length
// follow, then the payload bytes (each one result with its index), then
// two Fletcher-8 check bytes. The second check byte gives one frame-end
// result flagged good or bad, and hunting resumes. A wrong second sync
// byte is dropped and hunting restarts; that byte is not taken as a new
// first sync byte. Bytes outside a frame give no result.
`include "ubx_frame_receiver_assert.svh"

module ubx_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	ubxfr_rx_if.sink     rx,
	ubxfr_result_if.source result
);

	typedef enum logic [3:0] {
		ST_SYNC1,
		ST_SYNC2,
		ST_CLASS,
		ST_ID,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_PAYLOAD,
		ST_CK_A,
		ST_CK_B
	} state_t;

	state_t      state_q, state_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  ck_a_q, ck_a_d;

	logic        out_valid_q;
	ubxfr_pkg::kind_t out_kind_q;
	logic [7:0]  out_data_q;
	logic [15:0] out_index_q;
	logic [7:0]  out_class_q;
	logic [7:0]  out_id_q;
	logic [15:0] out_len_q;

	logic        accept;
	logic        emit;
	ubxfr_pkg::kind_t emit_kind;
	logic [7:0]  emit_data;
	logic [15:0] emit_index;
	logic [7:0]  b;

	ubxfr_pkg::fl_ctrl_t fl_ctrl;
	ubxfr_pkg::fl_sums_t fl_sums;

	// Take a byte whenever the output register is free or being drained.
	assign rx.ready = !out_valid_q || result.ready;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	ubxfr_fletcher u_fletcher (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fl_ctrl),
		.sums   (fl_sums)
	);

	// Frame decode for the byte on the input.
	always_comb begin
		state_d      = state_q;
		class_d      = class_q;
		id_d         = id_q;
		len_d        = len_q;
		cnt_d        = cnt_q;
		ck_a_d       = ck_a_q;
		emit         = 1'b0;
		emit_kind    = ubxfr_pkg::KIND_PAYLOAD;
		emit_data    = 8'd0;
		emit_index   = 16'd0;
		fl_ctrl.add   = 1'b0;
		fl_ctrl.clear = 1'b0;
		fl_ctrl.data  = b;
		case (state_q)
			ST_SYNC1: begin
				if (b == ubxfr_pkg::SYNC_FIRST) state_d = ST_SYNC2;
			end
			ST_SYNC2: begin
				state_d = (b == ubxfr_pkg::SYNC_SECOND) ? ST_CLASS : ST_SYNC1;
			end
			ST_CLASS: begin
				class_d       = b;
				fl_ctrl.add   = accept;
				fl_ctrl.clear = 1'b1;
				state_d       = ST_ID;
			end
			ST_ID: begin
				id_d        = b;
				fl_ctrl.add = accept;
				state_d     = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				len_d[7:0]  = b;
				fl_ctrl.add = accept;
				state_d     = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				len_d[15:8] = b;
				fl_ctrl.add = accept;
				cnt_d       = 16'd0;
				state_d     = ({b, len_q[7:0]} == 16'd0) ? ST_CK_A : ST_PAYLOAD;
			end
			ST_PAYLOAD: begin
				fl_ctrl.add = accept;
				emit        = 1'b1;
				emit_kind   = ubxfr_pkg::KIND_PAYLOAD;
				emit_data   = b;
				emit_index  = cnt_q;
				cnt_d       = cnt_q + 16'd1;
				if (cnt_q == len_q - 16'd1) state_d = ST_CK_A;
			end
			ST_CK_A: begin
				ck_a_d  = b;
				state_d = ST_CK_B;
			end
			ST_CK_B: begin
				emit      = 1'b1;
				emit_kind = ((ck_a_q == fl_sums.sum_a) && (b == fl_sums.sum_b)) ?
					ubxfr_pkg::KIND_GOOD : ubxfr_pkg::KIND_BAD;
				state_d   = ST_SYNC1;
			end
			default: begin
				state_d = ST_SYNC1;
			end
		endcase
	end

	// Frame state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SYNC1;
			class_q     <= 8'd0;
			id_q        <= 8'd0;
			len_q       <= 16'd0;
			cnt_q       <= 16'd0;
			ck_a_q      <= 8'd0;
			out_valid_q <= 1'b0;
			out_kind_q  <= ubxfr_pkg::KIND_PAYLOAD;
			out_data_q  <= 8'd0;
			out_index_q <= 16'd0;
			out_class_q <= 8'd0;
			out_id_q    <= 8'd0;
			out_len_q   <= 16'd0;
		end else begin
			if (accept) begin
				state_q <= state_d;
				class_q <= class_d;
				id_q    <= id_d;
				len_q   <= len_d;
				cnt_q   <= cnt_d;
				ck_a_q  <= ck_a_d;
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
				out_kind_q  <= emit_kind;
				out_data_q  <= emit_data;
				out_index_q <= emit_index;
				out_class_q <= class_q;
				out_id_q    <= id_q;
				out_len_q   <= len_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = out_kind_q;
	assign result.data_byte      = out_data_q;
	assign result.payload_index  = out_index_q;
	assign result.msg_class      = out_class_q;
	assign result.msg_id         = out_id_q;
	assign result.payload_length = out_len_q;

	// Checks on frame sequencing and result contents.
	`UBXFR_ASSERT_NEXT(a_end_to_hunt, clk, arst_n, accept && (state_q == ST_CK_B), state_q == ST_SYNC1, "frame end did not return to hunting")
	`UBXFR_ASSERT_IMPL(a_index_in_range, clk, arst_n, out_valid_q && (out_kind_q == ubxfr_pkg::KIND_PAYLOAD), out_index_q < out_len_q, "payload index beyond declared length")
	`UBXFR_ASSERT_IMPL(a_end_fields_zero, clk, arst_n, out_valid_q && (out_kind_q != ubxfr_pkg::KIND_PAYLOAD), (out_data_q == 8'd0) && (out_index_q == 16'd0), "frame end carries payload data")
	`UBXFR_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid_q, rx.ready, "byte refused with empty result register")

endmodule
